// ----- rtl/ptt_pkg.sv -----
// Package for the periodic timer table: payload types, codes and constants.
package ptt_pkg;

  localparam int unsigned TickPeriodReset = 10;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_REJECTED  = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_FIRED     = 3'd4,
    ST_TICK_DONE = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] handler;
    logic [31:0] delay_ms;
    logic [31:0] arg_a;
    logic [31:0] arg_b;
    logic [31:0] arg_c;
    logic [31:0] arg_d;
    logic [7:0]  slot;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot_index;
    logic [31:0] fired_handler;
    logic [31:0] out_arg_a;
    logic [31:0] out_arg_b;
    logic [31:0] out_arg_c;
    logic [31:0] out_arg_d;
    logic [31:0] tick_count;
    logic        last;
  } out_word_t;

  // One timer entry as it travels along the cell chain.
  typedef struct packed {
    logic [31:0]  handler;
    logic [31:0]  period;
    logic [31:0]  deadline;
    logic [127:0] args;
  } entry_t;

endpackage

// ----- rtl/ptt_div.sv -----
// Restoring divider for delay to ticks conversion, one quotient bit per cycle.
module ptt_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [9:0]  divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o
);
  logic [31:0] quot_q, quot_d;
  logic [9:0]  rem_q, rem_d;
  logic [9:0]  dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [10:0] trial;

  assign trial = {rem_q, quot_q[31]};

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = (divisor_i == '0) ? 10'd1 : divisor_i;
      cnt_d  = 6'd32;
      run_d  = 1'b1;
    end else if (run_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = 10'(trial - {1'b0, dvs_q});
        quot_d = {quot_q[30:0], 1'b1};
      end else begin
        rem_d  = trial[9:0];
        quot_d = {quot_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        run_d = 1'b0;
        // round up when a remainder is left
        if (rem_d != '0) quot_d = quot_d + 32'd1;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

// ----- rtl/ptt_cell.sv -----
// One timer cell of the rotating chain: holds an entry, passes it on when shifting.
module ptt_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  ptt_pkg::entry_t   entry_i,
  output ptt_pkg::entry_t   entry_o
);
  import ptt_pkg::*;

  entry_t entry_q, entry_d;

  always_comb begin
    entry_d = shift_i ? entry_i : entry_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;
endmodule

// ----- rtl/periodic_timer_table.sv -----
// Top level of the periodic timer table: sequencer, chain of timer cells, divider.
//
// SLOTS timer entries sit in a ring of cells that rotates by one cell per cycle
// during a ring turn; the sequencer works on the entry at the ring head. One
// item at a time: start is taken when busy is low. An accepted add runs the
// delay division, one turn of the ring and a closing state; a remove or a tick
// runs the ring turn and the closing state. A tick emits one word per fired
// slot in ascending slot order during the ring turn, then tick done. A
// rejected item is busy for one cycle. The closing word appears in the same
// cycle that busy drops. Results appear for one cycle on result_o with
// result_valid_o high; the receiver cannot stall them.
module periodic_timer_table #(
  parameter int unsigned SLOTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  ptt_pkg::in_word_t  item_i,
  output logic               busy_o,
  output logic               result_valid_o,
  output ptt_pkg::out_word_t result_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ptt_pkg::*;

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_ROT, S_DONE
  } state_e;

  state_e      state_q;
  in_word_t    item_q;
  logic [9:0]  tp_q;
  logic [31:0] tcnt_q;
  logic [31:0] period_q;
  logic [IdxW-1:0] idx_q;
  logic [IdxW:0]   cnt_q;
  logic        found_q;
  logic [IdxW-1:0] found_idx_q;
  logic        rv_q, rv_d;
  out_word_t   res_q, res_d;

  entry_t chain [SLOTS];
  entry_t head, head_new;
  logic   shift;
  logic   div_start, div_done;
  logic [31:0] div_q;
  logic   head_free, head_fire, rm_hit;

  // configuration port
  assign pready = 1'b1;
  assign prdata = {22'd0, tp_q};

  // ring of cells: cell k feeds cell k-1, head feeds back into the tail
  assign head = chain[0];
  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    entry_t nxt;
    if (k == SLOTS - 1) begin : g_tail
      assign nxt = head_new;
    end else begin : g_mid
      assign nxt = chain[k+1];
    end
    ptt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .entry_i (nxt),
      .entry_o (chain[k])
    );
  end

  // divider loads the delay of the word being accepted
  ptt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (item_i.delay_ms),
    .divisor_i  (tp_q),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  assign head_free = (head.handler == '0) && (head.deadline == '0);
  assign head_fire = (head.handler != '0) && (head.deadline < tcnt_q);
  assign rm_hit    = (item_q.slot[IdxW-1:0] == idx_q);
  assign shift     = (state_q == S_ROT) && (cnt_q != '0);

  // per-slot action on the entry leaving the head
  always_comb begin
    head_new = head;
    if (state_q == S_ROT) begin
      case (kind_e'(item_q.kind))
        KIND_ADD: begin
          if (!found_q && head_free) begin
            head_new.handler  = item_q.handler;
            head_new.period   = period_q;
            head_new.deadline = tcnt_q + period_q;
            head_new.args     = {item_q.arg_d, item_q.arg_c, item_q.arg_b, item_q.arg_a};
          end
        end
        KIND_REMOVE: begin
          if (rm_hit) begin
            head_new.handler  = '0;
            head_new.deadline = '0;
          end
        end
        KIND_TICK: begin
          if (head_fire) head_new.deadline = tcnt_q + head.period;
        end
        default: ;
      endcase
    end
  end

  assign div_start = (state_q == S_IDLE) && start_i && !busy_o &&
                     (kind_e'(item_i.kind) == KIND_ADD) &&
                     (item_i.handler != '0) && (item_i.delay_ms != '0);

  // result strobe: fired slots during a tick turn, closing word after done
  assign rv_d = (state_q == S_DONE) ||
                ((state_q == S_ROT) && (cnt_q != '0) &&
                 (kind_e'(item_q.kind) == KIND_TICK) && head_fire);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tp_q        <= 10'(TickPeriodReset);
      tcnt_q      <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      found_idx_q <= '0;
      rv_q        <= 1'b0;
    end else begin
      rv_q <= rv_d;
      if (psel && penable && pwrite && paddr == 2'd0) tp_q <= pwdata[9:0];
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            idx_q   <= '0;
            cnt_q   <= (IdxW+1)'(SLOTS);
            found_q <= 1'b0;
            case (kind_e'(item_i.kind))
              KIND_ADD: begin
                if (item_i.handler == '0 || item_i.delay_ms == '0) state_q <= S_DONE;
                else state_q <= S_DIV;
              end
              KIND_REMOVE: begin
                if (item_i.slot >= 8'(SLOTS)) state_q <= S_DONE;
                else state_q <= S_ROT;
              end
              KIND_TICK: begin
                tcnt_q  <= tcnt_q + 32'd1;
                state_q <= S_ROT;
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) state_q <= S_ROT;
        end
        S_ROT: begin
          if (cnt_q == '0) begin
            state_q <= S_DONE;
          end else begin
            cnt_q <= cnt_q - 1'b1;
            idx_q <= (idx_q == IdxW'(SLOTS - 1)) ? '0 : idx_q + 1'b1;
            if (kind_e'(item_q.kind) == KIND_ADD && !found_q && head_free) begin
              found_q     <= 1'b1;
              found_idx_q <= idx_q;
            end
          end
        end
        S_DONE: begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // next result word
  always_comb begin
    res_d = '0;
    res_d.tick_count = tcnt_q;
    if (state_q == S_ROT && cnt_q != '0) begin
      res_d.status        = ST_FIRED;
      res_d.slot_index    = 6'(idx_q);
      res_d.fired_handler = head.handler;
      res_d.out_arg_a     = head.args[31:0];
      res_d.out_arg_b     = head.args[63:32];
      res_d.out_arg_c     = head.args[95:64];
      res_d.out_arg_d     = head.args[127:96];
      res_d.last          = 1'b0;
    end else if (state_q == S_DONE) begin
      res_d.last   = 1'b1;
      res_d.status = ST_REJECTED;
      case (kind_e'(item_q.kind))
        KIND_ADD: begin
          if (item_q.handler == '0 || item_q.delay_ms == '0) begin
            res_d.status = ST_REJECTED;
          end else if (found_q) begin
            res_d.status     = ST_ADDED;
            res_d.slot_index = 6'(found_idx_q);
          end else begin
            res_d.status = ST_FULL;
          end
        end
        KIND_REMOVE: begin
          if (item_q.slot < 8'(SLOTS)) begin
            res_d.status     = ST_REMOVED;
            res_d.slot_index = item_q.slot[5:0];
          end
        end
        KIND_TICK: res_d.status = ST_TICK_DONE;
        default: res_d.status = ST_REJECTED;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) item_q <= item_i;
    if (div_done) period_q <= div_q;
    res_q <= res_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = rv_q;
  assign result_o       = res_q;

  // a full rotation returns the index to slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> (idx_q == '0))
    else $error("ring index not back at slot zero");
  // the tick counter only moves when a tick is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |=> $stable(tcnt_q))
    else $error("tick counter moved mid item");
  // a closing result always follows the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> (result_valid_o && result_o.last))
    else $error("missing final result");
endmodule

// ----- bench/tb_periodic_timer_table.sv -----
// Testbench for the periodic timer table: directed and random items, checked against a predictor.
`timescale 1ns / 1ps

module tb_periodic_timer_table;
  import ptt_pkg::*;

  localparam int unsigned Slots = 16;
  // Longest busy stretch of the block: divider plus one ring turn, with margin.
  localparam int unsigned DrainCycles = 80;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  in_word_t    item_i = '0;
  logic        busy_o;
  logic        result_valid_o;
  out_word_t   result_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  periodic_timer_table #(.SLOTS(Slots)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .item_i(item_i),
    .busy_o(busy_o), .result_valid_o(result_valid_o), .result_o(result_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Predicted table state
  logic [9:0]  tick_period;
  logic [31:0] tick_cnt;
  logic [31:0] handler_st [Slots];
  logic [31:0] period_st [Slots];
  logic [31:0] deadline_st [Slots];
  logic [31:0] arg_st [Slots][4];

  out_word_t expected_q [$];
  int errors = 0;
  bit quiet = 1'b0;

  function automatic out_word_t make_result(status_e st, int unsigned idx, logic [31:0] h,
                                            int unsigned s, bit with_args, bit lst);
    out_word_t r;
    r = '0;
    r.status = st;
    r.slot_index = idx[5:0];
    r.fired_handler = h;
    if (with_args) begin
      r.out_arg_a = arg_st[s][0];
      r.out_arg_b = arg_st[s][1];
      r.out_arg_c = arg_st[s][2];
      r.out_arg_d = arg_st[s][3];
    end
    r.tick_count = tick_cnt;
    r.last = lst;
    return r;
  endfunction

  // Work out the results of one accepted word and update the predicted state
  task automatic predict_timer_word(in_word_t w);
    logic [31:0] dt;
    logic [31:0] per;
    bit placed;
    placed = 1'b0;
    case (kind_e'(w.kind))
      KIND_ADD: begin
        if (w.handler == 0 || w.delay_ms == 0) begin
          expected_q.push_back(make_result(ST_REJECTED, 0, 0, 0, 0, 1));
        end else begin
          dt = (tick_period == 0) ? 32'd1 : {22'd0, tick_period};
          per = w.delay_ms / dt + ((w.delay_ms % dt) != 0 ? 32'd1 : 32'd0);
          for (int i = 0; i < Slots; i++) begin
            if (!placed && handler_st[i] == 0 && deadline_st[i] == 0) begin
              placed = 1'b1;
              handler_st[i] = w.handler;
              period_st[i] = per;
              deadline_st[i] = tick_cnt + per;
              arg_st[i][0] = w.arg_a;
              arg_st[i][1] = w.arg_b;
              arg_st[i][2] = w.arg_c;
              arg_st[i][3] = w.arg_d;
              expected_q.push_back(make_result(ST_ADDED, i, 0, 0, 0, 1));
            end
          end
          if (!placed) expected_q.push_back(make_result(ST_FULL, 0, 0, 0, 0, 1));
        end
      end
      KIND_REMOVE: begin
        if (w.slot >= Slots) begin
          expected_q.push_back(make_result(ST_REJECTED, 0, 0, 0, 0, 1));
        end else begin
          handler_st[w.slot[3:0]] = 0;
          deadline_st[w.slot[3:0]] = 0;
          expected_q.push_back(make_result(ST_REMOVED, w.slot, 0, 0, 0, 1));
        end
      end
      KIND_TICK: begin
        tick_cnt = tick_cnt + 1;
        for (int i = 0; i < Slots; i++) begin
          if (handler_st[i] != 0 && deadline_st[i] < tick_cnt) begin
            deadline_st[i] = tick_cnt + period_st[i];
            expected_q.push_back(make_result(ST_FIRED, i, handler_st[i], i, 1, 0));
          end
        end
        expected_q.push_back(make_result(ST_TICK_DONE, 0, 0, 0, 0, 1));
      end
      default: expected_q.push_back(make_result(ST_REJECTED, 0, 0, 0, 0, 1));
    endcase
  endtask

  // Send one word; start stays high so a back-to-back word needs no toggle
  task automatic send_word(in_word_t w);
    start_i <= 1'b1;
    item_i <= w;
    do @(posedge clk_i); while (busy_o);
    predict_timer_word(w);
  endtask

  // Random gap after a word: mostly none or short, a few long
  task automatic idle_gap();
    int unsigned n;
    int unsigned p;
    p = $urandom_range(99);
    if (quiet || p < 55) n = 0;
    else if (p < 90) n = $urandom_range(3, 1);
    else n = $urandom_range(40, 8);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    int unsigned guard;
    guard = 0;
    start_i <= 1'b0;
    while (expected_q.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // APB write of the tick period, only while idle
  task automatic write_tick_period(logic [31:0] v);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 2'd0;
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tick_period = v[9:0];
    @(posedge clk_i);
  endtask

  function automatic in_word_t make_word(kind_e k, logic [31:0] h, logic [31:0] d,
                                         logic [7:0] s);
    in_word_t w;
    w.kind = k;
    w.handler = h;
    w.delay_ms = d;
    w.arg_a = $urandom;
    w.arg_b = $urandom;
    w.arg_c = $urandom;
    w.arg_d = $urandom;
    w.slot = s;
    return w;
  endfunction

  task automatic put(in_word_t w);
    send_word(w);
    idle_gap();
  endtask

  // Rejections, extremes, remove corner cases and the unused kind
  task automatic test_directed();
    in_word_t w;
    put(make_word(KIND_ADD, 0, 100, 0));
    put(make_word(KIND_ADD, 32'h1234, 0, 0));
    w = make_word(KIND_ADD, '1, '1, '1);
    w.arg_a = '1; w.arg_b = '1; w.arg_c = '1; w.arg_d = '1;
    put(w);
    put(make_word(KIND_ADD, 32'h1, 32'd1, 0));
    put(make_word(KIND_ADD, 32'h55, 32'd25, 0));
    put(make_word(KIND_REMOVE, 0, 0, 8'd255));
    put(make_word(KIND_REMOVE, 0, 0, 8'd16));
    put(make_word(KIND_REMOVE, 0, 0, 8'd15));
    put(make_word(KIND_NONE, '1, '1, '1));
    repeat (4) put(make_word(KIND_TICK, 0, 0, 0));
    put(make_word(KIND_REMOVE, 0, 0, 8'd1));
    put(make_word(KIND_ADD, 32'h77, 32'd9, 0));
    put(make_word(KIND_TICK, 0, 0, 0));
  endtask

  // Deadline that wraps to zero keeps its slot taken
  task automatic test_wrapped_deadline();
    write_tick_period(32'd1);
    // tick count is 5 now; period 2^32-5 wraps the deadline to zero
    put(make_word(KIND_REMOVE, 0, 0, 8'd3));
    put(make_word(KIND_ADD, 32'hABCD, 32'hFFFF_FFFB, 0));
    put(make_word(KIND_ADD, 32'hBEEF, 32'd3, 0));
    repeat (2) put(make_word(KIND_TICK, 0, 0, 0));
  endtask

  // Add Slots+1 entries so the table fills and later adds find it full, then two ticks
  task automatic test_table_full();
    quiet = 1'b1;
    for (int i = 0; i < Slots + 1; i++) put(make_word(KIND_ADD, $urandom | 1, 2, 0));
    put(make_word(KIND_TICK, 0, 0, 0));
    put(make_word(KIND_TICK, 0, 0, 0));
    quiet = 1'b0;
  endtask

  // Random mix of adds, removes, ticks and the unused kind under one tick period
  task automatic test_random_phase(logic [31:0] tp, int unsigned count);
    in_word_t w;
    int unsigned p;
    logic [31:0] h;
    logic [31:0] d;
    write_tick_period(tp);
    for (int n = 0; n < count; n++) begin
      quiet = (n % 60) > 45;
      p = $urandom_range(99);
      h = ($urandom_range(19) == 0) ? 32'd0 : $urandom;
      d = ($urandom_range(19) == 0) ? 32'd0
        : ($urandom_range(9) == 0) ? $urandom : $urandom_range(3000, 1);
      if (p < 40) w = make_word(KIND_TICK, $urandom, $urandom, 8'($urandom));
      else if (p < 72) w = make_word(KIND_ADD, h, d, 8'($urandom));
      else if (p < 95) w = make_word(KIND_REMOVE, $urandom, $urandom,
                                     8'(($urandom_range(9) == 0) ? $urandom
                                                                 : $urandom_range(15)));
      else w = make_word(KIND_NONE, $urandom, $urandom, 8'($urandom));
      put(w);
    end
    quiet = 1'b0;
  endtask

  task automatic chk_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t: %s mismatch: expected %h actual %h", $time, name, e, a);
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    out_word_t e;
    if (rst_ni && result_valid_o) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none actual %h", $time, result_o);
      end else begin
        e = expected_q.pop_front();
        chk_field("status", 32'(e.status), 32'(result_o.status));
        chk_field("slot_index", 32'(e.slot_index), 32'(result_o.slot_index));
        chk_field("fired_handler", e.fired_handler, result_o.fired_handler);
        chk_field("out_arg_a", e.out_arg_a, result_o.out_arg_a);
        chk_field("out_arg_b", e.out_arg_b, result_o.out_arg_b);
        chk_field("out_arg_c", e.out_arg_c, result_o.out_arg_c);
        chk_field("out_arg_d", e.out_arg_d, result_o.out_arg_d);
        chk_field("tick_count", e.tick_count, result_o.tick_count);
        chk_field("last", 32'(e.last), 32'(result_o.last));
      end
    end
  end

  // Sequence
  initial begin
    tick_period = 10'(TickPeriodReset);
    tick_cnt = 0;
    for (int i = 0; i < Slots; i++) begin
      handler_st[i] = 0;
      period_st[i] = 0;
      deadline_st[i] = 0;
      for (int j = 0; j < 4; j++) arg_st[i][j] = 0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_wrapped_deadline();
    test_table_full();
    test_random_phase(32'd1000, 110);
    test_random_phase(32'd1, 110);
    test_random_phase($urandom_range(1000, 1), 110);
    test_random_phase(32'd0, 60);
    test_random_phase(32'd1023, 40);
    wait_drained();
    if (expected_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results missing: expected %h actual none", $time,
               expected_q.size(), expected_q[0]);
    end
    if (errors == 0) begin
      $display("[periodic_timer_table] OK");
    end else begin
      $display("[periodic_timer_table] ERROR");
    end
    $finish;
  end

  // Timeout
  initial begin
    #5ms;
    $display("[periodic_timer_table] ERROR");
    $finish;
  end

endmodule
